// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PNGH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PNGH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pngh_pkg.sv =====
`timescale 1ns / 1ps

package pngh_pkg;

  typedef enum logic [2:0] {
    PNGH_ST_OK           = 3'd0,
    PNGH_ST_TOO_SHORT    = 3'd1,
    PNGH_ST_BAD_SIG      = 3'd2,
    PNGH_ST_NO_LENGTH    = 3'd3,
    PNGH_ST_NO_IHDR      = 3'd4,
    PNGH_ST_WIDTH_SHORT  = 3'd5,
    PNGH_ST_HEIGHT_SHORT = 3'd6
  } pngh_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } pngh_in_t;

  typedef struct packed {
    pngh_status_t status;
    logic [31:0]  image_width;
    logic [31:0]  image_height;
  } pngh_out_t;

  localparam logic [7:0] PNGH_SIG [8] = '{
    8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
  };

  localparam logic [7:0] PNGH_IHDR [4] = '{8'h49, 8'h48, 8'h44, 8'h52};

  localparam logic [4:0] PNGH_POS_SIG_END    = 5'd7;
  localparam logic [4:0] PNGH_POS_LEN_START  = 5'd8;
  localparam logic [4:0] PNGH_POS_LEN_END    = 5'd11;
  localparam logic [4:0] PNGH_POS_TYPE_START = 5'd12;
  localparam logic [4:0] PNGH_POS_TYPE_END   = 5'd15;
  localparam logic [4:0] PNGH_POS_WID_START  = 5'd16;
  localparam logic [4:0] PNGH_POS_WID_END    = 5'd19;
  localparam logic [4:0] PNGH_POS_HGT_START  = 5'd20;
  localparam logic [4:0] PNGH_POS_HGT_END    = 5'd23;

endpackage

// ===== rtl/pngh_parse.sv =====
`timescale 1ns / 1ps

module pngh_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  pngh_pkg::pngh_in_t  item,
  output logic                emit,
  output pngh_pkg::pngh_out_t res
);
  import pngh_pkg::*;

  logic [4:0]  byte_position;
  logic        signature_bad;
  logic        type_bad;
  logic [31:0] width_shift;
  logic [31:0] height_shift;
  logic        skipping_rest;

  logic         sig_bad_next;
  logic         type_bad_next;
  logic [31:0]  width_next;
  logic [31:0]  height_next;
  logic         in_sig;
  logic         in_type;
  logic         in_wid;
  logic         in_hgt;
  pngh_status_t status;
  pngh_status_t early_status;

  assign in_sig  = byte_position <= PNGH_POS_SIG_END;
  assign in_type = (byte_position >= PNGH_POS_TYPE_START) && (byte_position <= PNGH_POS_TYPE_END);
  assign in_wid  = (byte_position >= PNGH_POS_WID_START) && (byte_position <= PNGH_POS_WID_END);
  assign in_hgt  = byte_position >= PNGH_POS_HGT_START;

  assign sig_bad_next  = signature_bad |
                         (in_sig && (item.data_byte != PNGH_SIG[byte_position[2:0]]));
  assign type_bad_next = type_bad |
                         (in_type && (item.data_byte != PNGH_IHDR[byte_position[1:0]]));
  assign width_next    = in_wid ? {width_shift[23:0], item.data_byte} : width_shift;
  assign height_next   = in_hgt ? {height_shift[23:0], item.data_byte} : height_shift;

  always_comb begin
    priority if (byte_position < PNGH_POS_SIG_END) begin
      early_status = PNGH_ST_TOO_SHORT;
    end else if (byte_position < PNGH_POS_LEN_END) begin
      early_status = PNGH_ST_NO_LENGTH;
    end else if (byte_position < PNGH_POS_TYPE_END) begin
      early_status = PNGH_ST_NO_IHDR;
    end else if (byte_position < PNGH_POS_WID_END) begin
      early_status = PNGH_ST_WIDTH_SHORT;
    end else begin
      early_status = PNGH_ST_HEIGHT_SHORT;
    end
  end

  always_comb begin
    emit   = 1'b0;
    status = PNGH_ST_OK;
    if (!skipping_rest) begin
      priority if ((byte_position == PNGH_POS_SIG_END) && sig_bad_next) begin
        emit   = 1'b1;
        status = PNGH_ST_BAD_SIG;
      end else if ((byte_position == PNGH_POS_TYPE_END) && type_bad_next) begin
        emit   = 1'b1;
        status = PNGH_ST_NO_IHDR;
      end else if (byte_position >= PNGH_POS_HGT_END) begin
        emit   = 1'b1;
        status = PNGH_ST_OK;
      end else if (item.last_byte) begin
        emit   = 1'b1;
        status = early_status;
      end else begin
        emit   = 1'b0;
      end
    end
  end

  assign res.status       = status;
  assign res.image_width  = (status == PNGH_ST_OK) ? width_next : '0;
  assign res.image_height = (status == PNGH_ST_OK) ? height_next : '0;

  always_ff @(posedge clk) begin
    if (rst || (fire && item.last_byte)) begin
      byte_position <= '0;
      signature_bad <= 1'b0;
      type_bad      <= 1'b0;
      width_shift   <= '0;
      height_shift  <= '0;
      skipping_rest <= 1'b0;
    end else if (fire && !skipping_rest) begin
      signature_bad <= sig_bad_next;
      type_bad      <= type_bad_next;
      width_shift   <= width_next;
      height_shift  <= height_next;
      if (emit) begin
        skipping_rest <= 1'b1;
      end else begin
        byte_position <= byte_position + 5'd1;
      end
    end
  end

endmodule

// ===== rtl/png_header_dimension_parser_core.sv =====
`timescale 1ns / 1ps

// Channel | Signals                               | Carries
// input   | byte_valid, byte_ready, byte_data     | one file byte and last-byte flag
// output  | result_valid, result_ready, result_data | status, width, height
//
// One byte a cycle unless results stall; results come from the result register.
// The input register and the result register each hold one request.
// Rate is set by the single parse stage between them.
// Synchronous reset clears the parser state and both valid flags.
// A stalled result holds the parse stage, which then holds the input register.

module png_header_dimension_parser_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  pngh_pkg::pngh_in_t  byte_data,
  output logic                result_valid,
  input  logic                result_ready,
  output pngh_pkg::pngh_out_t result_data
);
  import pngh_pkg::*;

  logic      in_vld;
  pngh_in_t  in_q;
  logic      adv;
  logic      emit;
  pngh_out_t res;

  assign adv        = in_vld && (!result_valid || result_ready);
  assign byte_ready = !in_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      in_vld <= 1'b1;
    end else if (adv) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      in_q <= byte_data;
    end
  end

  pngh_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .fire (adv),
    .item (in_q),
    .emit (emit),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      result_data <= res;
    end
  end

endmodule

// ===== rtl/pngh_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pngh_checker (
  input logic                clk,
  input logic                rst,
  input logic                byte_valid,
  input logic                byte_ready,
  input logic                result_valid,
  input logic                result_ready,
  input pngh_pkg::pngh_out_t result_data
);
  import pngh_pkg::*;

  logic stalled;
  logic err_res;
  logic dims_zero;
  logic byte_taken;

  assign stalled    = result_valid && !result_ready;
  assign err_res    = result_valid && (result_data.status != PNGH_ST_OK);
  assign dims_zero  = (result_data.image_width == '0) && (result_data.image_height == '0);
  assign byte_taken = byte_valid && byte_ready;

  `PNGH_ASSERT(a_result_hold, stalled |=> result_valid && $stable(result_data), "result lost")
  `PNGH_ASSERT(a_error_zero_dims, err_res |-> dims_zero, "error result carries dimensions")
  `PNGH_ASSERT(a_result_from_byte, $rose(result_valid) |-> $past(byte_taken, 2), "stray result")
  `PNGH_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !result_valid, "result valid after reset")

endmodule

bind png_header_dimension_parser_core pngh_checker u_pngh_checker (.*);
